[hdl/frtr_pkg.sv]
package frtr_pkg;

   localparam int MAX_PARTS  = 1024;
   localparam int OLD_WINDOW = 25;
   localparam int HDR_BYTES  = 10;

   localparam int WORD_W    = (MAX_PARTS >= 64) ? 32 : 4;
   localparam int WSEL_W    = $clog2(WORD_W);
   localparam int WORDS     = (MAX_PARTS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = $clog2(WORDS);
   localparam int ADDR_W    = WIDX_W + 1;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int COUNT_W   = $clog2(MAX_PARTS + 1);
   localparam int DIV_STEPS = 32;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [7:0]  OLD_LIMIT = 8'(256 - OLD_WINDOW);
   localparam logic [10:0] HDR_LEN   = 11'(HDR_BYTES);
   localparam logic [7:0]  REV_OK    = 8'd1;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_SHORT    = 3'd1,
      STAT_BAD_REV  = 3'd2,
      STAT_RANGE    = 3'd3,
      STAT_OLD      = 3'd4,
      STAT_DISABLED = 3'd5,
      STAT_TOO_MANY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_DIV,
      S_SLOT,
      S_READ,
      S_MODIFY
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

[hdl/frtr_ram.sv]
module frtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/frtr_div.sv]
module frtr_div (
   input  logic                  clock,
   input  logic                  reset,
   input  frtr_pkg::div_req_type req,
   output frtr_pkg::div_rsp_type rsp
);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [frtr_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [31:0]                 quo_ff, quo_in;
   logic [15:0]                 rem_ff, rem_in;
   logic [15:0]                 dvs_ff, dvs_in;
   logic [16:0]                 rem_shift;
   logic [17:0]                 diff;
   logic                        ge;

   assign rem_shift = {rem_ff, quo_ff[31]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign ge        = !diff[17];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[15:0] : rem_shift[15:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == frtr_pkg::STEP_W'(frtr_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff + 32'(rem_ff != 16'd0);

endmodule

[hdl/frame_fragment_reassembly_tracker.sv]
// Header rejects (disabled, short, revision, range, old) strobe from S_CHECK after S_MUL; too
// many parts or a part beyond the slot total from S_SLOT after the 32-step divider; accepted
// parts from S_MODIFY after S_READ. Busy drops with the strobe unless a sweep follows. A restart
// sweeps each dirty part-bit RAM half before an accepted result or after an S_SLOT range reject;
// a done frame sweeps its half (slot 1: all dirty halves) after. Synchronous reset: enable on,
// slots empty, both halves swept. Results are strobed for one cycle; the receiver cannot stall them.
module frame_fragment_reassembly_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [10:0] req_packet_length,
   input  logic [7:0]  req_protocol_revision,
   input  logic [7:0]  req_frame_number,
   input  logic [15:0] req_part_number,
   input  logic [15:0] req_part_size_limit,
   input  logic [31:0] req_total_frame_bytes,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_target_slot,
   output logic [31:0] rsp_write_offset,
   output logic [10:0] rsp_payload_bytes,
   output logic        rsp_frame_done,
   output logic [7:0]  rsp_done_frame_number,
   output logic [31:0] rsp_done_frame_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_rx_enable
);

   localparam int CW = frtr_pkg::COUNT_W;
   localparam int WW = frtr_pkg::WORD_W;
   localparam int SW = frtr_pkg::WSEL_W;
   localparam int IW = frtr_pkg::WIDX_W;
   localparam int AW = frtr_pkg::ADDR_W;

   frtr_pkg::state_type  state_ff, state_in;
   logic                 pending_ff, pending_in;
   logic                 rx_enable_ff, rx_enable_in;
   logic [7:0]           expected_ff, expected_in;
   logic [1:0]           in_use_ff, in_use_in;
   logic [1:0][31:0]     bytes_ff, bytes_in;
   logic [1:0][CW-1:0]   total_ff, total_in;
   logic [1:0][CW-1:0]   count_ff, count_in;
   logic                 order_ff, order_in;
   logic [1:0]           dirty_ff, dirty_in;
   logic [1:0]           mask_ff, mask_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 slot_ff, slot_in;

   logic [10:0]          len_ff, len_in;
   logic [7:0]           rev_ff, rev_in;
   logic [7:0]           frame_ff, frame_in;
   logic [15:0]          part_ff, part_in;
   logic [15:0]          psize_ff, psize_in;
   logic [31:0]          fbytes_ff, fbytes_in;
   logic [31:0]          offset_ff, offset_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   frtr_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_slot_ff, rsp_slot_in;
   logic [31:0]          rsp_offset_ff, rsp_offset_in;
   logic [10:0]          rsp_payload_ff, rsp_payload_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic [7:0]           rsp_dnum_ff, rsp_dnum_in;
   logic [31:0]          rsp_dbytes_ff, rsp_dbytes_in;

   frtr_pkg::div_req_type div_req;
   frtr_pkg::div_rsp_type div_rsp;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WW-1:0]        ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [WW-1:0]        ram_rd_data;

   logic                 csr_write;
   logic                 item_accept;

   logic [32:0]          c_sum;
   logic                 c_err;
   frtr_pkg::status_type c_status;

   logic                 p_slot;
   logic [1:0]           p_in_use;
   logic [1:0][31:0]     p_bytes;
   logic [1:0][CW-1:0]   p_total;
   logic [1:0][CW-1:0]   p_count;
   logic                 p_order;
   logic [7:0]           p_exp;
   logic [1:0]           p_mask;
   logic                 p_too_many;
   logic                 p_range_err;

   logic                 m_bit;
   logic [CW-1:0]        m_count;
   logic                 m_done;
   logic                 m_half;
   logic [1:0]           m_half_bit;
   logic [WW-1:0]        m_word;
   logic [1:0]           m_mask;

   logic                 clr_half;
   logic                 clr_last;
   logic [1:0]           clr_mask_after;

   frtr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   frtr_ram #(
      .WIDTH (WW),
      .DEPTH (frtr_pkg::RAM_DEPTH)
   ) u_bits (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy        = (state_ff != frtr_pkg::S_IDLE);
   assign csr_ready   = !busy && !start;
   assign csr_write   = csr_valid && csr_ready;
   assign item_accept = start && !busy;

   always_comb begin
      c_sum    = {1'b0, offset_ff} + 33'(psize_ff);
      c_err    = 1'b1;
      c_status = frtr_pkg::STAT_OK;
      if (!rx_enable_ff) begin
         c_status = frtr_pkg::STAT_DISABLED;
      end else if (len_ff < frtr_pkg::HDR_LEN) begin
         c_status = frtr_pkg::STAT_SHORT;
      end else if (rev_ff != frtr_pkg::REV_OK) begin
         c_status = frtr_pkg::STAT_BAD_REV;
      end else if (psize_ff == 16'd0 || c_sum[32] || offset_ff >= fbytes_ff) begin
         c_status = frtr_pkg::STAT_RANGE;
      end else if (8'(frame_ff - expected_ff) >= frtr_pkg::OLD_LIMIT) begin
         c_status = frtr_pkg::STAT_OLD;
      end else begin
         c_err = 1'b0;
      end
   end

   always_comb begin
      p_too_many = div_rsp.quotient > 32'(frtr_pkg::MAX_PARTS);
      p_slot     = 1'b0;
      p_in_use   = in_use_ff;
      p_bytes    = bytes_ff;
      p_total    = total_ff;
      p_count    = count_ff;
      p_order    = order_ff;
      p_exp      = expected_ff;
      p_mask     = mask_ff;
      if (frame_ff == expected_ff) begin
         p_slot = 1'b0;
      end else if (frame_ff == 8'(expected_ff + 8'd1) && in_use_ff[0]) begin
         p_slot = 1'b1;
      end else begin
         p_in_use = '0;
         p_bytes  = '0;
         p_total  = '0;
         p_count  = '0;
         p_order  = 1'b0;
         p_exp    = frame_ff;
         p_mask   = mask_ff | dirty_ff;
      end
      if (!p_in_use[p_slot]) begin
         p_in_use[p_slot] = 1'b1;
         p_bytes[p_slot]  = fbytes_ff;
         p_total[p_slot]  = div_rsp.quotient[CW-1:0];
         p_count[p_slot]  = '0;
      end else if (fbytes_ff > p_bytes[p_slot]) begin
         p_bytes[p_slot] = fbytes_ff;
         p_total[p_slot] = div_rsp.quotient[CW-1:0];
      end
      p_range_err = 32'(part_ff) >= 32'(p_total[p_slot]);
   end

   always_comb begin
      m_bit      = ram_rd_data[part_ff[SW-1:0]];
      m_count    = count_ff[slot_ff] + CW'(!m_bit);
      m_done     = (m_count == total_ff[slot_ff]);
      m_half     = slot_ff ^ order_ff;
      m_half_bit = 2'b01 << m_half;
      m_word     = ram_rd_data | (WW'(1) << part_ff[SW-1:0]);
      m_mask     = mask_ff;
      if (m_done) begin
         if (!slot_ff) begin
            m_mask = mask_ff | m_half_bit;
         end else begin
            m_mask = mask_ff | dirty_ff | m_half_bit;
         end
      end
   end

   assign clr_half       = !mask_ff[0];
   assign clr_last       = (idx_ff == IW'(frtr_pkg::WORDS - 1));
   assign clr_mask_after = mask_ff & ~(2'b01 << clr_half);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = {m_half, part_ff[SW +: IW]};
      ram_wr_data = m_word;
      if (state_ff == frtr_pkg::S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {clr_half, idx_ff};
         ram_wr_data = '0;
      end else if (state_ff == frtr_pkg::S_MODIFY && !m_bit) begin
         ram_wr_en = 1'b1;
      end
      ram_rd_en   = (state_ff == frtr_pkg::S_READ);
      ram_rd_addr = {slot_ff ^ order_ff, part_ff[SW +: IW]};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frtr_pkg::S_CLEAR: begin
            if (clr_last && clr_mask_after == 2'b00) begin
               state_in = pending_ff ? frtr_pkg::S_READ : frtr_pkg::S_IDLE;
            end
         end
         frtr_pkg::S_IDLE: begin
            if (csr_write && !csr_rx_enable && dirty_ff != 2'b00) begin
               state_in = frtr_pkg::S_CLEAR;
            end else if (item_accept) begin
               state_in = frtr_pkg::S_MUL;
            end
         end
         frtr_pkg::S_MUL: begin
            state_in = frtr_pkg::S_CHECK;
         end
         frtr_pkg::S_CHECK: begin
            state_in = c_err ? frtr_pkg::S_IDLE : frtr_pkg::S_DIV;
         end
         frtr_pkg::S_DIV: begin
            if (div_rsp.done) begin
               state_in = frtr_pkg::S_SLOT;
            end
         end
         frtr_pkg::S_SLOT: begin
            if (p_too_many) begin
               state_in = frtr_pkg::S_IDLE;
            end else if (p_mask != 2'b00) begin
               state_in = frtr_pkg::S_CLEAR;
            end else if (p_range_err) begin
               state_in = frtr_pkg::S_IDLE;
            end else begin
               state_in = frtr_pkg::S_READ;
            end
         end
         frtr_pkg::S_READ: begin
            state_in = frtr_pkg::S_MODIFY;
         end
         frtr_pkg::S_MODIFY: begin
            state_in = (m_mask != 2'b00) ? frtr_pkg::S_CLEAR : frtr_pkg::S_IDLE;
         end
         default: begin
            state_in = frtr_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      pending_in     = pending_ff;
      rx_enable_in   = rx_enable_ff;
      expected_in    = expected_ff;
      in_use_in      = in_use_ff;
      bytes_in       = bytes_ff;
      total_in       = total_ff;
      count_in       = count_ff;
      order_in       = order_ff;
      dirty_in       = dirty_ff;
      mask_in        = mask_ff;
      idx_in         = idx_ff;
      slot_in        = slot_ff;
      len_in         = len_ff;
      rev_in         = rev_ff;
      frame_in       = frame_ff;
      part_in        = part_ff;
      psize_in       = psize_ff;
      fbytes_in      = fbytes_ff;
      offset_in      = offset_ff;
      div_req.start    = 1'b0;
      div_req.dividend = fbytes_ff;
      div_req.divisor  = psize_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = frtr_pkg::STAT_OK;
      rsp_slot_in    = 1'b0;
      rsp_offset_in  = '0;
      rsp_payload_in = '0;
      rsp_done_in    = 1'b0;
      rsp_dnum_in    = '0;
      rsp_dbytes_in  = '0;
      case (state_ff)
         frtr_pkg::S_CLEAR: begin
            if (clr_last) begin
               idx_in             = '0;
               mask_in            = clr_mask_after;
               dirty_in[clr_half] = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         frtr_pkg::S_IDLE: begin
            if (csr_write) begin
               rx_enable_in = csr_rx_enable;
               if (!csr_rx_enable) begin
                  expected_in = '0;
                  in_use_in   = '0;
                  bytes_in    = '0;
                  total_in    = '0;
                  count_in    = '0;
                  order_in    = 1'b0;
                  mask_in     = dirty_ff;
                  pending_in  = 1'b0;
               end
            end
            if (item_accept) begin
               len_in    = req_packet_length;
               rev_in    = req_protocol_revision;
               frame_in  = req_frame_number;
               part_in   = req_part_number;
               psize_in  = req_part_size_limit;
               fbytes_in = req_total_frame_bytes;
            end
         end
         frtr_pkg::S_MUL: begin
            offset_in = {16'd0, part_ff} * {16'd0, psize_ff};
         end
         frtr_pkg::S_CHECK: begin
            if (c_err) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = c_status;
            end else begin
               div_req.start = 1'b1;
            end
         end
         frtr_pkg::S_DIV: begin
         end
         frtr_pkg::S_SLOT: begin
            if (p_too_many) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = frtr_pkg::STAT_TOO_MANY;
            end else begin
               in_use_in   = p_in_use;
               bytes_in    = p_bytes;
               total_in    = p_total;
               count_in    = p_count;
               order_in    = p_order;
               expected_in = p_exp;
               mask_in     = p_mask;
               slot_in     = p_slot;
               if (p_range_err) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frtr_pkg::STAT_RANGE;
                  rsp_slot_in   = p_slot;
               end else begin
                  pending_in = 1'b1;
               end
            end
         end
         frtr_pkg::S_READ: begin
            pending_in = 1'b0;
         end
         frtr_pkg::S_MODIFY: begin
            if (!m_bit) begin
               dirty_in[m_half] = 1'b1;
            end
            count_in[slot_ff] = m_count;
            rsp_valid_in   = 1'b1;
            rsp_status_in  = frtr_pkg::STAT_OK;
            rsp_slot_in    = slot_ff;
            rsp_offset_in  = offset_ff;
            rsp_payload_in = len_ff - frtr_pkg::HDR_LEN;
            if (m_done) begin
               rsp_done_in   = 1'b1;
               rsp_dnum_in   = frame_ff;
               rsp_dbytes_in = bytes_ff[slot_ff];
               mask_in       = m_mask;
               if (!slot_ff) begin
                  in_use_in   = {1'b0, in_use_ff[1]};
                  bytes_in    = {32'd0, bytes_ff[1]};
                  total_in    = {CW'(0), total_ff[1]};
                  count_in    = {CW'(0), count_ff[1]};
                  order_in    = !order_ff;
                  expected_in = expected_ff + 8'd1;
               end else begin
                  in_use_in   = '0;
                  bytes_in    = '0;
                  total_in    = '0;
                  count_in    = '0;
                  order_in    = 1'b0;
                  expected_in = expected_ff + 8'd2;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frtr_pkg::S_CLEAR;
         pending_ff   <= 1'b0;
         rx_enable_ff <= 1'b1;
         expected_ff  <= '0;
         in_use_ff    <= '0;
         bytes_ff     <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         dirty_ff     <= 2'b11;
         mask_ff      <= 2'b11;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rx_enable_ff <= rx_enable_in;
         expected_ff  <= expected_in;
         in_use_ff    <= in_use_in;
         bytes_ff     <= bytes_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         order_ff     <= order_in;
         dirty_ff     <= dirty_in;
         mask_ff      <= mask_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff        <= slot_in;
      len_ff         <= len_in;
      rev_ff         <= rev_in;
      frame_ff       <= frame_in;
      part_ff        <= part_in;
      psize_ff       <= psize_in;
      fbytes_ff      <= fbytes_in;
      offset_ff      <= offset_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_dnum_ff    <= rsp_dnum_in;
      rsp_dbytes_ff  <= rsp_dbytes_in;
   end

   assign rsp_strobe            = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_target_slot       = rsp_slot_ff;
   assign rsp_write_offset      = rsp_offset_ff;
   assign rsp_payload_bytes     = rsp_payload_ff;
   assign rsp_frame_done        = rsp_done_ff;
   assign rsp_done_frame_number = rsp_dnum_ff;
   assign rsp_done_frame_bytes  = rsp_dbytes_ff;

`ifndef SYNTHESIS
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != 2'b00) |-> busy)
      else $error("clear sweep pending while idle");

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      in_use_ff[1] |-> in_use_ff[0])
      else $error("slot 1 open without slot 0");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= CW'(frtr_pkg::MAX_PARTS)) && (count_ff[1] <= CW'(frtr_pkg::MAX_PARTS)))
      else $error("part count above part capacity");

   a_done_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != frtr_pkg::STAT_OK) |-> !rsp_frame_done)
      else $error("frame done on rejected item");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      item_accept |=> busy)
      else $error("not busy after item accepted");
`endif

endmodule

[bench/frame_fragment_reassembly_tracker_tb.sv]
`timescale 1ns / 100ps

module frame_fragment_reassembly_tracker_tb;

   typedef struct {
      logic [10:0] len;
      logic [7:0]  rev;
      logic [7:0]  frm;
      logic [15:0] part;
      logic [15:0] psize;
      logic [31:0] fbytes;
      int          gap;
   } header_type;

   typedef struct {
      frtr_pkg::status_type status;
      logic                 slot;
      logic [31:0]          offset;
      logic [10:0]          payload;
      logic                 done;
      logic [7:0]           done_frame;
      logic [31:0]          done_bytes;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [10:0] req_packet_length;
   logic [7:0]  req_protocol_revision;
   logic [7:0]  req_frame_number;
   logic [15:0] req_part_number;
   logic [15:0] req_part_size_limit;
   logic [31:0] req_total_frame_bytes;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic        rsp_target_slot;
   logic [31:0] rsp_write_offset;
   logic [10:0] rsp_payload_bytes;
   logic        rsp_frame_done;
   logic [7:0]  rsp_done_frame_number;
   logic [31:0] rsp_done_frame_bytes;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_rx_enable;

   frame_fragment_reassembly_tracker dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_packet_length     (req_packet_length),
      .req_protocol_revision (req_protocol_revision),
      .req_frame_number      (req_frame_number),
      .req_part_number       (req_part_number),
      .req_part_size_limit   (req_part_size_limit),
      .req_total_frame_bytes (req_total_frame_bytes),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_target_slot       (rsp_target_slot),
      .rsp_write_offset      (rsp_write_offset),
      .rsp_payload_bytes     (rsp_payload_bytes),
      .rsp_frame_done        (rsp_frame_done),
      .rsp_done_frame_number (rsp_done_frame_number),
      .rsp_done_frame_bytes  (rsp_done_frame_bytes),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_rx_enable         (csr_rx_enable)
   );

   header_type  pending[$];
   verdict_type verdicts[$];
   header_type  cur;
   int          gap_left;
   bit          failed;
   bit          no_gaps;
   int          frame_cursor;

   logic        rx_on;
   logic [7:0]  next_frame;
   logic        in_use[2];
   logic [31:0] slot_size[2];
   int          part_total[2];
   int          part_count[2];
   logic        seen[2 * frtr_pkg::MAX_PARTS];
   logic        half_swap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_slot(input int s);
      int base;
      base = ((s ^ half_swap) & 1) * frtr_pkg::MAX_PARTS;
      in_use[s] = 1'b0;
      slot_size[s] = '0;
      part_total[s] = 0;
      part_count[s] = 0;
      for (int i = 0; i < frtr_pkg::MAX_PARTS; i++) seen[base + i] = 1'b0;
   endtask

   task automatic clear_tracker();
      half_swap = 1'b0;
      clear_slot(0);
      clear_slot(1);
      next_frame = '0;
   endtask

   task automatic track_header(input header_type p);
      verdict_type e;
      logic [63:0] off;
      logic [63:0] parts;
      int          s;
      int          idx;
      e = '{frtr_pkg::STAT_OK, 1'b0, '0, '0, 1'b0, '0, '0};
      off = 64'(p.part) * 64'(p.psize);
      if (!rx_on) e.status = frtr_pkg::STAT_DISABLED;
      else if (p.len < frtr_pkg::HDR_LEN) e.status = frtr_pkg::STAT_SHORT;
      else if (p.rev != frtr_pkg::REV_OK) e.status = frtr_pkg::STAT_BAD_REV;
      else if (p.psize == 0) e.status = frtr_pkg::STAT_RANGE;
      else if ((64'(p.part) + 1) * 64'(p.psize) > 64'hFFFF_FFFF || off >= 64'(p.fbytes))
         e.status = frtr_pkg::STAT_RANGE;
      else if (8'(p.frm - next_frame) >= frtr_pkg::OLD_LIMIT) e.status = frtr_pkg::STAT_OLD;
      else begin
         parts = (64'(p.fbytes) + 64'(p.psize) - 1) / 64'(p.psize);
         if (parts > frtr_pkg::MAX_PARTS) e.status = frtr_pkg::STAT_TOO_MANY;
         else begin
            if (p.frm == next_frame) s = 0;
            else if (p.frm == 8'(next_frame + 1) && in_use[0]) s = 1;
            else begin
               clear_tracker();
               next_frame = p.frm;
               s = 0;
            end
            if (!in_use[s]) begin
               clear_slot(s);
               in_use[s] = 1'b1;
               slot_size[s] = p.fbytes;
               part_total[s] = int'(parts);
            end else if (p.fbytes > slot_size[s]) begin
               slot_size[s] = p.fbytes;
               part_total[s] = int'(parts);
            end
            e.slot = s[0];
            if (int'(p.part) >= part_total[s]) e.status = frtr_pkg::STAT_RANGE;
            else begin
               e.offset = off[31:0];
               e.payload = p.len - frtr_pkg::HDR_LEN;
               idx = ((s ^ half_swap) & 1) * frtr_pkg::MAX_PARTS + int'(p.part);
               if (!seen[idx]) begin
                  seen[idx] = 1'b1;
                  part_count[s]++;
               end
               if (part_count[s] == part_total[s]) begin
                  e.done = 1'b1;
                  e.done_frame = p.frm;
                  e.done_bytes = slot_size[s];
                  if (s == 0) begin
                     clear_slot(0);
                     in_use[0] = in_use[1];
                     slot_size[0] = slot_size[1];
                     part_total[0] = part_total[1];
                     part_count[0] = part_count[1];
                     half_swap = ~half_swap;
                     clear_slot(1);
                     next_frame = next_frame + 8'd1;
                  end else begin
                     clear_slot(0);
                     clear_slot(1);
                     next_frame = next_frame + 8'd2;
                  end
               end
            end
         end
      end
      verdicts.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (start && !busy) begin
         track_header(cur);
         gap_left = cur.gap;
         if (gap_left == 0 && pending.size() > 0) begin
            cur = pending.pop_front();
            req_packet_length <= cur.len;
            req_protocol_revision <= cur.rev;
            req_frame_number <= cur.frm;
            req_part_number <= cur.part;
            req_part_size_limit <= cur.psize;
            req_total_frame_bytes <= cur.fbytes;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending.size() > 0) begin
            cur = pending.pop_front();
            req_packet_length <= cur.len;
            req_protocol_revision <= cur.rev;
            req_frame_number <= cur.frm;
            req_part_number <= cur.part;
            req_part_size_limit <= cur.psize;
            req_total_frame_bytes <= cur.fbytes;
            start <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_strobe) begin
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            failed = 1'b1;
         end else begin
            e = verdicts.pop_front();
            if (rsp_status !== e.status || rsp_target_slot !== e.slot
                || rsp_write_offset !== e.offset || rsp_payload_bytes !== e.payload
                || rsp_frame_done !== e.done || rsp_done_frame_number !== e.done_frame
                || rsp_done_frame_bytes !== e.done_bytes) begin
               $display("%0t: expected st=%0d slot=%0d off=%0h pay=%0d done=%0d fn=%0d fb=%0h",
                        $time, e.status, e.slot, e.offset, e.payload, e.done,
                        e.done_frame, e.done_bytes);
               $display("%0t: actual   st=%0d slot=%0d off=%0h pay=%0d done=%0d fn=%0d fb=%0h",
                        $time, rsp_status, rsp_target_slot, rsp_write_offset,
                        rsp_payload_bytes, rsp_frame_done, rsp_done_frame_number,
                        rsp_done_frame_bytes);
               failed = 1'b1;
            end
         end
      end
   end

   function automatic int pick_gap();
      if (no_gaps || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 5) == 0) return $urandom_range(20, 90);
      return $urandom_range(1, 5);
   endfunction

   task automatic add_header(input logic [10:0] len, input logic [7:0] rev,
                             input logic [7:0] frm, input logic [15:0] part,
                             input logic [15:0] psize, input logic [31:0] fbytes);
      header_type h;
      h = '{len, rev, frm, part, psize, fbytes, pick_gap()};
      pending.push_back(h);
   endtask

   task automatic add_noise();
      logic [7:0] frm;
      frm = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                        : 8'(frame_cursor - $urandom_range(1, 30));
      add_header(11'($urandom),
                 ($urandom_range(0, 2) == 0) ? 8'($urandom) : frtr_pkg::REV_OK, frm,
                 16'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic add_frames();
      int          n[2];
      logic [15:0] ps[2];
      logic [31:0] fb[2];
      int          tag[$];
      int          two;
      int          j;
      int          t;
      logic [31:0] b;
      two = $urandom_range(0, 2) == 0;
      for (int f = 0; f <= two; f++) begin
         n[f] = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
         ps[f] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 1490));
         fb[f] = 32'((n[f] - 1) * ps[f]) + $urandom_range(1, ps[f]);
         for (int i = 0; i < n[f]; i++) begin
            tag.push_back(f * 65536 + i);
            if ($urandom_range(0, 7) == 0) tag.push_back(f * 65536 + i);
         end
      end
      for (int i = tag.size() - 1; i > 1; i--) begin
         j = $urandom_range(1, i);
         t = tag[i];
         tag[i] = tag[j];
         tag[j] = t;
      end
      if ($urandom_range(0, 9) == 0 && tag.size() > 1) tag.delete(tag.size() - 1);
      foreach (tag[i]) begin
         t = tag[i] / 65536;
         b = fb[t];
         if ($urandom_range(0, 9) == 0) b = b + $urandom_range(0, 3 * ps[t]);
         else if ($urandom_range(0, 9) == 0) b = b - $urandom_range(0, ps[t] - 1);
         add_header(11'($urandom_range(10, 1500)), frtr_pkg::REV_OK, 8'(frame_cursor + t),
                    16'(tag[i] % 65536), ps[t], b);
         if ($urandom_range(0, 19) == 0) add_noise();
      end
      frame_cursor = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                   : (frame_cursor + two + 1) % 256;
   endtask

   task automatic wait_quiet();
      do @(posedge clock); while (pending.size() > 0 || start || verdicts.size() > 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_enable(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_rx_enable <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      rx_on = v;
      if (!v) begin
         clear_tracker();
         frame_cursor = 0;
      end
   endtask

   task automatic run_random(input int count);
      int goal;
      goal = pending.size() + count;
      while (pending.size() < goal) begin
         if ($urandom_range(0, 9) == 0) add_noise();
         else add_frames();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_rx_enable = 1'b1;
      req_packet_length = '0;
      req_protocol_revision = '0;
      req_frame_number = '0;
      req_part_number = '0;
      req_part_size_limit = '0;
      req_total_frame_bytes = '0;
      failed = 1'b0;
      no_gaps = 1'b0;
      frame_cursor = 0;
      rx_on = 1'b1;
      clear_tracker();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      add_header(11'd0, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd10, 32'd100);
      add_header(11'd9, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd10, 32'd100);
      add_header(11'd100, 8'd0, 8'd0, 16'd0, 16'd10, 32'd100);
      add_header(11'd100, 8'd255, 8'd0, 16'd0, 16'd10, 32'd100);
      add_header(11'd100, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd0, 32'd100);
      add_header(11'd100, frtr_pkg::REV_OK, 8'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_header(11'd100, frtr_pkg::REV_OK, 8'd0, 16'd5, 16'd10, 32'd50);
      add_header(11'd100, frtr_pkg::REV_OK, 8'd255, 16'd0, 16'd10, 32'd50);
      add_header(11'd100, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd1, 32'd1025);
      add_header(11'd2047, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd100, 32'd250);
      add_header(11'd10, frtr_pkg::REV_OK, 8'd1, 16'd1, 16'd100, 32'd150);
      add_header(11'd50, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd100, 32'd250);
      add_header(11'd60, frtr_pkg::REV_OK, 8'd0, 16'd2, 16'd100, 32'd350);
      add_header(11'd70, frtr_pkg::REV_OK, 8'd0, 16'd1, 16'd100, 32'd150);
      add_header(11'd80, frtr_pkg::REV_OK, 8'd0, 16'd3, 16'd100, 32'd350);
      add_header(11'd90, frtr_pkg::REV_OK, 8'd1, 16'd0, 16'd100, 32'd150);
      add_header(11'd11, frtr_pkg::REV_OK, 8'd3, 16'd0, 16'd1, 32'd1);
      add_header(11'd20, frtr_pkg::REV_OK, 8'd4, 16'd0, 16'd10, 32'd20);
      add_header(11'd20, frtr_pkg::REV_OK, 8'd5, 16'd0, 16'd10, 32'd10);
      add_header(11'd1500, frtr_pkg::REV_OK, 8'd100, 16'd1023, 16'd1, 32'd1024);
      add_header(11'd1501, frtr_pkg::REV_OK, 8'd0, 16'd0, 16'd1, 32'd2);
      wait_quiet();

      write_enable(1'b1);
      frame_cursor = 0;
      run_random(500);
      wait_quiet();
      write_enable(1'b0);
      run_random(30);
      wait_quiet();
      write_enable(1'b0);
      write_enable(1'b1);
      run_random(500);
      wait_quiet();
      write_enable(1'b0);
      write_enable(1'b1);
      no_gaps = 1'b1;
      run_random(300);
      wait_quiet();

      if (!failed && verdicts.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
